@@ hdl/mst_pkg.sv @@
`default_nettype none
package mst_pkg;

    localparam int LABEL_W  = 5;
    localparam int WEIGHT_W = 16;
    localparam int VCNT_W   = 6;

    typedef struct packed {
        logic [LABEL_W-1:0]  s;
        logic [LABEL_W-1:0]  e;
        logic [WEIGHT_W-1:0] w;
    } t_edge;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SORT_GO,
        ST_SORT_WAIT,
        ST_NEXT,
        ST_FETCH,
        ST_FIND_U,
        ST_GO_V,
        ST_FIND_V,
        ST_PUSH_MID,
        ST_FINISH
    } t_state;

    typedef enum logic [1:0] {
        SO_IDLE,
        SO_GOT_CUR,
        SO_CMP,
        SO_PLACE
    } t_sort_state;

    typedef enum logic [1:0] {
        UF_IDLE,
        UF_WALK,
        UF_WAIT
    } t_uf_state;

endpackage
`default_nettype wire

@@ hdl/mst_if.sv @@
`default_nettype none
interface mst_edge_if;
    logic        valid;
    logic        ready;
    logic [4:0]  edge_start;
    logic [4:0]  edge_end;
    logic [15:0] edge_weight;
    logic        last_edge;
    modport source (output valid, edge_start, edge_end, edge_weight, last_edge, input ready);
    modport sink (input valid, edge_start, edge_end, edge_weight, last_edge, output ready);
endinterface

interface mst_tree_if;
    logic        valid;
    logic        ready;
    logic [4:0]  tree_start;
    logic [4:0]  tree_end;
    logic [15:0] tree_weight;
    logic        last_result;
    logic        tree_complete;
    logic        no_edge;
    modport source (output valid, tree_start, tree_end, tree_weight, last_result,
                    tree_complete, no_edge, input ready);
    modport sink (input valid, tree_start, tree_end, tree_weight, last_result,
                  tree_complete, no_edge, output ready);
endinterface

interface mst_cfg_if;
    logic       valid;
    logic       ready;
    logic [5:0] vertex_count;
    modport source (output valid, vertex_count, input ready);
    modport sink (input valid, vertex_count, output ready);
endinterface
`default_nettype wire

@@ hdl/mst_sort.sv @@
`default_nettype none
module mst_sort #(
    parameter int MAX_EDGES = 64,
    localparam int AW = $clog2(MAX_EDGES),
    localparam int CW = $clog2(MAX_EDGES + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  mst_pkg::t_edge i_wr_data,
    input  logic          i_start,
    input  logic [CW-1:0] i_count,
    output logic          o_idle,
    input  logic [AW-1:0] i_rd_addr,
    output mst_pkg::t_edge o_rd_data
);
    import mst_pkg::*;

    t_edge       mem [MAX_EDGES];
    t_edge       r_rdata;
    t_edge       r_cur, n_cur;
    t_sort_state r_state, n_state;
    logic [CW-1:0] r_i, n_i, r_j, n_j, r_n, n_n;
    logic          we;
    logic [AW-1:0] waddr, raddr;
    t_edge         wdata;
    logic [CW-1:0] i_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SO_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_i   <= n_i;
        r_j   <= n_j;
        r_n   <= n_n;
        r_cur <= n_cur;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rdata <= mem[raddr];
    end

    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_n     = r_n;
        n_cur   = r_cur;
        we      = 1'b0;
        waddr   = i_wr_addr;
        wdata   = i_wr_data;
        raddr   = i_rd_addr;
        i_inc   = r_i + CW'(1);
        case (r_state)
            SO_IDLE: begin
                we = i_wr_en;
                if (i_start) begin
                    n_n = i_count;
                    n_i = CW'(1);
                    if (i_count > CW'(1)) begin
                        raddr   = AW'(1);
                        n_state = SO_GOT_CUR;
                    end
                end
            end
            SO_GOT_CUR: begin
                n_cur   = r_rdata;
                n_j     = r_i;
                raddr   = AW'(r_i - CW'(1));
                n_state = SO_CMP;
            end
            SO_CMP: begin
                if (r_rdata.w > r_cur.w) begin
                    we    = 1'b1;
                    waddr = r_j[AW-1:0];
                    wdata = r_rdata;
                    n_j   = r_j - CW'(1);
                    if (r_j != CW'(1)) begin
                        raddr = AW'(r_j - CW'(2));
                    end else begin
                        n_state = SO_PLACE;
                    end
                end else begin
                    we    = 1'b1;
                    waddr = r_j[AW-1:0];
                    wdata = r_cur;
                    n_i   = i_inc;
                    if (i_inc < r_n) begin
                        raddr   = i_inc[AW-1:0];
                        n_state = SO_GOT_CUR;
                    end else begin
                        n_state = SO_IDLE;
                    end
                end
            end
            SO_PLACE: begin
                we    = 1'b1;
                waddr = '0;
                wdata = r_cur;
                n_i   = i_inc;
                if (i_inc < r_n) begin
                    raddr   = i_inc[AW-1:0];
                    n_state = SO_GOT_CUR;
                end else begin
                    n_state = SO_IDLE;
                end
            end
            default: begin
                n_state = SO_IDLE;
            end
        endcase
    end

    assign o_idle    = (r_state == SO_IDLE);
    assign o_rd_data = r_rdata;

endmodule
`default_nettype wire

@@ hdl/mst_uf.sv @@
`default_nettype none
module mst_uf #(
    parameter int MAX_VERTS = 32,
    localparam int VW = $clog2(MAX_VERTS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_clear,
    input  logic          i_find,
    input  logic [VW-1:0] i_vertex,
    output logic          o_done,
    output logic [VW-1:0] o_root,
    input  logic          i_link,
    input  logic [VW-1:0] i_link_dst,
    input  logic [VW-1:0] i_link_src
);
    import mst_pkg::*;

    logic [VW-1:0]        parent [MAX_VERTS];
    logic [VW-1:0]        r_rdata;
    logic [MAX_VERTS-1:0] r_is_root;
    logic [VW-1:0]        r_v, n_v;
    t_uf_state            r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= UF_IDLE;
            r_is_root <= '1;
        end else begin
            r_state <= n_state;
            if (i_clear) begin
                r_is_root <= '1;
            end else if (i_link) begin
                r_is_root[i_link_dst] <= 1'b0;
            end
        end
        r_v <= n_v;
    end

    always_ff @(posedge i_clk) begin
        if (i_link) begin
            parent[i_link_dst] <= i_link_src;
        end
        r_rdata <= parent[r_v];
    end

    always_comb begin
        n_state = r_state;
        n_v     = r_v;
        o_done  = 1'b0;
        case (r_state)
            UF_IDLE: begin
                if (i_find) begin
                    n_v     = i_vertex;
                    n_state = UF_WALK;
                end
            end
            UF_WALK: begin
                if (r_is_root[r_v]) begin
                    o_done  = 1'b1;
                    n_state = UF_IDLE;
                end else begin
                    n_state = UF_WAIT;
                end
            end
            UF_WAIT: begin
                n_v     = r_rdata;
                n_state = UF_WALK;
            end
            default: begin
                n_state = UF_IDLE;
            end
        endcase
    end

    assign o_root = r_v;

endmodule
`default_nettype wire

@@ hdl/min_spanning_tree_kruskal.sv @@
`default_nettype none
// Kruskal minimum spanning tree. While the block is idle, edges load one beat per cycle into
// an edge memory; the beat marked last starts the run. A stable insertion sort then runs
// through the single read and write port of that memory. The scan then fetches the sorted
// edges in order until they run out or the tree is complete, and makes two root searches,
// one for each end of the edge, walking the parent links in the parent memory. The block
// accepts no edge beats from the last beat until the final result is handed to the output
// register. One result beat per accepted edge follows, the last one flagged, and a run that
// accepts no edge gives one beat flagged no_edge.
module min_spanning_tree_kruskal #(
    parameter int MAX_VERTS = 32,
    parameter int MAX_EDGES = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mst_cfg_if.sink    i_cfg,
    mst_edge_if.sink   i_edge,
    mst_tree_if.source o_tree
);
    import mst_pkg::*;

    localparam int AW = $clog2(MAX_EDGES);
    localparam int CW = $clog2(MAX_EDGES + 1);
    localparam int VW = $clog2(MAX_VERTS);

    t_state        r_state, n_state;
    logic [VCNT_W-1:0] r_vc;
    logic [CW-1:0] r_cnt, n_cnt, r_i, n_i;
    logic [VW-1:0] r_target, n_target, r_acc, n_acc, r_ru, n_ru;
    t_edge         r_cur, n_cur, r_pedge, n_pedge;
    logic          r_pend, n_pend;
    logic          r_ov, n_ov;
    t_edge         r_oedge, n_oedge;
    logic          r_olast, n_olast, r_ofull, n_ofull, r_onone, n_onone;

    logic          beat, slot;
    logic          wr_en, sort_start, sort_idle;
    t_edge         wr_data, rd_data;
    logic          uf_clear, uf_find, uf_done, uf_link;
    logic [VW-1:0] uf_vertex, uf_root;
    int            tgt;

    assign i_cfg.ready = 1'b1;
    assign beat        = i_edge.valid && i_edge.ready;
    assign slot        = !r_ov || o_tree.ready;
    assign wr_data     = '{s: i_edge.edge_start, e: i_edge.edge_end, w: i_edge.edge_weight};

    mst_sort #(.MAX_EDGES(MAX_EDGES)) u_sort (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_cnt[AW-1:0]),
        .i_wr_data (wr_data),
        .i_start   (sort_start),
        .i_count   (r_cnt),
        .o_idle    (sort_idle),
        .i_rd_addr (r_i[AW-1:0]),
        .o_rd_data (rd_data)
    );

    mst_uf #(.MAX_VERTS(MAX_VERTS)) u_uf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (uf_clear),
        .i_find     (uf_find),
        .i_vertex   (uf_vertex),
        .o_done     (uf_done),
        .o_root     (uf_root),
        .i_link     (uf_link),
        .i_link_dst (uf_root),
        .i_link_src (r_ru)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_vc    <= VCNT_W'(1);
            r_cnt   <= '0;
            r_acc   <= '0;
            r_pend  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                r_vc <= i_cfg.vertex_count;
            end
            r_cnt  <= n_cnt;
            r_acc  <= n_acc;
            r_pend <= n_pend;
            r_ov   <= n_ov;
        end
        r_i      <= n_i;
        r_target <= n_target;
        r_ru     <= n_ru;
        r_cur    <= n_cur;
        r_pedge  <= n_pedge;
        r_oedge  <= n_oedge;
        r_olast  <= n_olast;
        r_ofull  <= n_ofull;
        r_onone  <= n_onone;
    end

    always_comb begin
        if (r_vc == '0) begin
            tgt = 0;
        end else if (int'(r_vc) > MAX_VERTS) begin
            tgt = MAX_VERTS - 1;
        end else begin
            tgt = int'(r_vc) - 1;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_i        = r_i;
        n_target   = r_target;
        n_acc      = r_acc;
        n_ru       = r_ru;
        n_cur      = r_cur;
        n_pend     = r_pend;
        n_pedge    = r_pedge;
        n_ov       = r_ov && !o_tree.ready;
        n_oedge    = r_oedge;
        n_olast    = r_olast;
        n_ofull    = r_ofull;
        n_onone    = r_onone;
        i_edge.ready = 1'b0;
        wr_en      = 1'b0;
        sort_start = 1'b0;
        uf_clear   = 1'b0;
        uf_find    = 1'b0;
        uf_vertex  = VW'(r_cur.e);
        uf_link    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                i_edge.ready = 1'b1;
                if (beat) begin
                    if (int'(r_cnt) < MAX_EDGES) begin
                        wr_en = 1'b1;
                        n_cnt = r_cnt + CW'(1);
                    end
                    if (i_edge.last_edge) begin
                        n_target = VW'(tgt);
                        n_state  = ST_SORT_GO;
                    end
                end
            end
            ST_SORT_GO: begin
                sort_start = 1'b1;
                uf_clear   = 1'b1;
                n_acc      = '0;
                n_i        = '0;
                n_pend     = 1'b0;
                n_state    = ST_SORT_WAIT;
            end
            ST_SORT_WAIT: begin
                if (sort_idle) begin
                    n_state = ST_NEXT;
                end
            end
            ST_NEXT: begin
                if (r_i < r_cnt && r_acc < r_target) begin
                    n_state = ST_FETCH;
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_FETCH: begin
                n_cur = rd_data;
                n_i   = r_i + CW'(1);
                if (int'(rd_data.s) < MAX_VERTS && int'(rd_data.e) < MAX_VERTS) begin
                    uf_find   = 1'b1;
                    uf_vertex = VW'(rd_data.s);
                    n_state   = ST_FIND_U;
                end else begin
                    n_state = ST_NEXT;
                end
            end
            ST_FIND_U: begin
                if (uf_done) begin
                    n_ru    = uf_root;
                    n_state = ST_GO_V;
                end
            end
            ST_GO_V: begin
                uf_find   = 1'b1;
                uf_vertex = VW'(r_cur.e);
                n_state   = ST_FIND_V;
            end
            ST_FIND_V: begin
                if (uf_done) begin
                    if (uf_root == r_ru) begin
                        n_state = ST_NEXT;
                    end else begin
                        uf_link = 1'b1;
                        n_acc   = r_acc + VW'(1);
                        if (r_pend) begin
                            n_state = ST_PUSH_MID;
                        end else begin
                            n_pend  = 1'b1;
                            n_pedge = r_cur;
                            n_state = ST_NEXT;
                        end
                    end
                end
            end
            ST_PUSH_MID: begin
                if (slot) begin
                    n_ov    = 1'b1;
                    n_oedge = r_pedge;
                    n_olast = 1'b0;
                    n_ofull = 1'b0;
                    n_onone = 1'b0;
                    n_pedge = r_cur;
                    n_state = ST_NEXT;
                end
            end
            ST_FINISH: begin
                if (slot) begin
                    n_ov    = 1'b1;
                    n_olast = 1'b1;
                    if (r_pend) begin
                        n_oedge = r_pedge;
                        n_ofull = (r_acc == r_target);
                        n_onone = 1'b0;
                    end else begin
                        n_oedge = '0;
                        n_ofull = (r_target == '0);
                        n_onone = 1'b1;
                    end
                    n_pend  = 1'b0;
                    n_cnt   = '0;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_tree.valid         = r_ov;
    assign o_tree.tree_start    = r_oedge.s;
    assign o_tree.tree_end      = r_oedge.e;
    assign o_tree.tree_weight   = r_oedge.w;
    assign o_tree.last_result   = r_olast;
    assign o_tree.tree_complete = r_ofull;
    assign o_tree.no_edge       = r_onone;

    a_acc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE && r_state != ST_SORT_GO) |-> r_acc <= r_target)
        else $error("accepted count passed the target");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_cnt) <= MAX_EDGES)
        else $error("edge count beyond capacity");

    a_no_edge_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_onone) |-> (r_olast && r_oedge == '0))
        else $error("empty result malformed");

    a_full_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_ofull) |-> r_olast)
        else $error("complete flag on a non-final beat");

endmodule
`default_nettype wire

@@ tb/min_spanning_tree_kruskal_tb.sv @@
`default_nettype none
module min_spanning_tree_kruskal_tb;
    import mst_pkg::*;

    localparam int NV = 32;
    localparam int NE = 64;
    localparam int STALL_LIMIT = 200000;

    typedef struct {
        logic [4:0]  s;
        logic [4:0]  e;
        logic [15:0] w;
        logic        last;
    } t_beat;

    typedef struct {
        logic [4:0]  s;
        logic [4:0]  e;
        logic [15:0] w;
        logic        last;
        logic        full;
        logic        none;
    } t_tree_beat;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    mst_cfg_if  cfg_ch();
    mst_edge_if edge_ch();
    mst_tree_if tree_ch();

    min_spanning_tree_kruskal dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (cfg_ch.sink),
        .i_edge (edge_ch.sink),
        .o_tree (tree_ch.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_beat      pending_edges[$];
    t_tree_beat expected_tree[$];
    t_edge      loaded_edges[$];
    logic [5:0] vcount_shadow;
    int         error_count = 0;
    int         idle_cycles = 0;
    int         gap_left = 0;
    int         stall_left = 0;
    int         burst_mode = 0;
    logic       cfg_req = 1'b0;
    logic [5:0] cfg_value = 6'd0;

    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode != 0) begin
            return 0;
        end
        if (r < 55) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(5, 40);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    // Computes the tree beats that a last-marked edge releases from the loaded edges.
    task automatic predict_tree();
        t_edge      sorted[$];
        t_edge      cur;
        logic [5:0] parent[NV];
        logic       root[NV];
        int         n;
        int         target;
        int         taken;
        int         ru;
        int         rv;
        int         steps;
        int         j;
        t_tree_beat tb;
        sorted = loaded_edges;
        for (int i = 1; i < sorted.size(); i++) begin
            cur = sorted[i];
            j = i;
            while (j > 0 && sorted[j-1].w > cur.w) begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = cur;
        end
        n = vcount_shadow;
        if (n == 0) n = 1;
        if (n > NV) n = NV;
        target = n - 1;
        for (int i = 0; i < NV; i++) begin
            parent[i] = 0;
            root[i] = 1'b1;
        end
        taken = 0;
        for (int i = 0; i < sorted.size() && taken < target; i++) begin
            cur = sorted[i];
            ru = cur.s;
            steps = 0;
            while (!root[ru] && steps < NV) begin
                ru = parent[ru];
                steps++;
            end
            rv = cur.e;
            steps = 0;
            while (!root[rv] && steps < NV) begin
                rv = parent[rv];
                steps++;
            end
            if (ru != rv) begin
                parent[rv] = ru;
                root[rv] = 1'b0;
                tb = '{cur.s, cur.e, cur.w, 1'b0, 1'b0, 1'b0};
                expected_tree.push_back(tb);
                taken++;
            end
        end
        if (taken == 0) begin
            tb = '{5'd0, 5'd0, 16'd0, 1'b1, target == 0, 1'b1};
            expected_tree.push_back(tb);
        end else begin
            expected_tree[$].last = 1'b1;
            expected_tree[$].full = (taken == target);
        end
        loaded_edges.delete();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            edge_ch.valid <= 1'b0;
            edge_ch.edge_start <= '0;
            edge_ch.edge_end <= '0;
            edge_ch.edge_weight <= '0;
            edge_ch.last_edge <= 1'b0;
        end else begin
            if (edge_ch.valid && edge_ch.ready) begin
                if (loaded_edges.size() < NE) begin
                    loaded_edges.push_back('{edge_ch.edge_start, edge_ch.edge_end,
                                             edge_ch.edge_weight});
                end
                if (edge_ch.last_edge) begin
                    predict_tree();
                end
                gap_left = random_gap();
            end
            if (!edge_ch.valid || edge_ch.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    edge_ch.valid <= 1'b0;
                end else if (pending_edges.size() > 0) begin
                    edge_ch.valid <= 1'b1;
                    edge_ch.edge_start <= pending_edges[0].s;
                    edge_ch.edge_end <= pending_edges[0].e;
                    edge_ch.edge_weight <= pending_edges[0].w;
                    edge_ch.last_edge <= pending_edges[0].last;
                    void'(pending_edges.pop_front());
                end else begin
                    edge_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_ch.valid <= 1'b0;
            cfg_ch.vertex_count <= '0;
        end else if (cfg_ch.valid && cfg_ch.ready) begin
            vcount_shadow = cfg_ch.vertex_count;
            cfg_ch.valid <= 1'b0;
            cfg_req <= 1'b0;
        end else if (cfg_req) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.vertex_count <= cfg_value;
        end
    end

    always @(posedge i_clk) begin
        t_tree_beat want;
        if (!i_rst_n) begin
            tree_ch.ready <= 1'b0;
        end else begin
            if (tree_ch.valid && tree_ch.ready) begin
                if (expected_tree.size() == 0) begin
                    report_mismatch("unexpected beat, start", tree_ch.tree_start, -1);
                end else begin
                    want = expected_tree.pop_front();
                    if (tree_ch.tree_start !== want.s)
                        report_mismatch("tree_start", tree_ch.tree_start, want.s);
                    if (tree_ch.tree_end !== want.e)
                        report_mismatch("tree_end", tree_ch.tree_end, want.e);
                    if (tree_ch.tree_weight !== want.w)
                        report_mismatch("tree_weight", tree_ch.tree_weight, want.w);
                    if (tree_ch.last_result !== want.last)
                        report_mismatch("last_result", tree_ch.last_result, want.last);
                    if (tree_ch.tree_complete !== want.full)
                        report_mismatch("tree_complete", tree_ch.tree_complete, want.full);
                    if (tree_ch.no_edge !== want.none)
                        report_mismatch("no_edge", tree_ch.no_edge, want.none);
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                tree_ch.ready <= 1'b0;
            end else begin
                tree_ch.ready <= 1'b1;
                stall_left = random_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if ((edge_ch.valid && edge_ch.ready) || (tree_ch.valid && tree_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("min_spanning_tree_kruskal verification failed");
            $finish;
        end
    end

    task automatic queue_edge(input int s, input int e, input int w, input bit last);
        t_beat b;
        b = '{s[4:0], e[4:0], w[15:0], last};
        pending_edges.push_back(b);
    endtask

    // Checks at the falling edge, after every rising-edge update has settled.
    task automatic wait_drained();
        while (pending_edges.size() > 0 || edge_ch.valid || expected_tree.size() > 0)
            @(negedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_vertex_count(input int v);
        wait_drained();
        cfg_value = v[5:0];
        cfg_req = 1'b1;
        @(posedge i_clk);
        while (cfg_req) @(posedge i_clk);
    endtask

    // A random graph; most edges join vertices in 0..vmax, the rest any vertex in 0..31, random weights.
    task automatic queue_graph(input int nedges, input int vmax);
        int s;
        int e;
        for (int i = 0; i < nedges; i++) begin
            if ($urandom_range(0, 9) < 8) begin
                s = $urandom_range(0, vmax);
                e = $urandom_range(0, vmax);
            end else begin
                s = $urandom_range(0, 31);
                e = $urandom_range(0, 31);
            end
            queue_edge(s, e, $urandom_range(0, 3) == 0 ? $urandom_range(0, 7)
                                                      : $urandom_range(0, 65535),
                       i == nedges - 1);
        end
    endtask

    initial begin
        int vc;
        int ne;
        edge_ch.valid = 1'b0;
        edge_ch.edge_start = '0;
        edge_ch.edge_end = '0;
        edge_ch.edge_weight = '0;
        edge_ch.last_edge = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.vertex_count = '0;
        tree_ch.ready = 1'b0;
        vcount_shadow = 6'd1;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset vertex count of one: nothing accepted, complete.
        queue_edge(0, 1, 5, 1'b1);
        write_vertex_count(4);
        queue_edge(0, 1, 65535, 1'b0);
        queue_edge(1, 1, 0, 1'b0);
        queue_edge(1, 2, 7, 1'b0);
        queue_edge(2, 0, 7, 1'b0);
        queue_edge(31, 3, 1, 1'b0);
        queue_edge(2, 3, 7, 1'b1);
        queue_edge(5, 5, 3, 1'b1);
        write_vertex_count(0);
        queue_edge(31, 30, 9, 1'b1);
        write_vertex_count(63);
        queue_edge(0, 31, 2, 1'b0);
        queue_edge(31, 0, 1, 1'b1);
        write_vertex_count(32);
        for (int i = 0; i < 70; i++)
            queue_edge(i % 32, (i + 1) % 32, 70 - i, i == 69);

        repeat (12) begin
            write_vertex_count($urandom_range(0, 63));
            vc = (vcount_shadow == 0) ? 1 : (vcount_shadow > 32 ? 32 : vcount_shadow);
            ne = $urandom_range(1, 6);
            burst_mode = ($urandom_range(0, 3) == 0);
            queue_graph(ne, vc - 1);
        end
        write_vertex_count(32);
        queue_graph(30, 31);
        wait_drained();
        if (error_count == 0 && expected_tree.size() == 0) begin
            $display("min_spanning_tree_kruskal verification clean");
        end else begin
            $display("min_spanning_tree_kruskal verification failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
